[rtl/imm_pkg.sv]
// shared types and constants for the integer matrix multiply unit
// no dependencies
package imm_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 16;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned DIM_W           = 5;
    localparam int unsigned IDX_W           = 4;
    localparam int unsigned CFG_IDX_W       = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    // request codes
    localparam logic [1:0] REQ_STORE_A = 2'd0;
    localparam logic [1:0] REQ_STORE_B = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [DATA_W-1:0] element_value;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] product_value;
        logic                     range_error;
    } out_word_t;

    typedef struct packed {
        logic clear;
        logic mul_valid;
        logic mul_last;
    } mac_ctl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
        logic [DIM_W-1:0] r;
        r = (32'(v) > lim) ? DIM_W'(lim) : v;
        return r;
    endfunction

endpackage

[rtl/imm_ram.sv]
// generic single port ram with registered read
// no dependencies
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/imm_mac.sv]
// multiply-accumulate datapath: registered product, then running sum
// depends on imm_pkg
module imm_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imm_pkg::mac_ctl_t             ctl,
    input  logic [imm_pkg::DATA_W-1:0]    a_data,
    input  logic [imm_pkg::DATA_W-1:0]    b_data,
    output logic                          done,
    output logic [imm_pkg::DATA_W-1:0]    sum
);

    logic [imm_pkg::DATA_W-1:0] prod_reg;
    logic [imm_pkg::DATA_W-1:0] prod_next;
    logic [imm_pkg::DATA_W-1:0] acc_reg;
    logic [imm_pkg::DATA_W-1:0] acc_next;
    logic                       pv_reg;
    logic                       plast_reg;

    // low word of the product is the same for signed and unsigned
    assign prod_next = a_data * b_data;
    assign acc_next  = acc_reg + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
        end
        else
        begin
            pv_reg    <= ctl.mul_valid;
            plast_reg <= ctl.mul_valid & ctl.mul_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_valid)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = pv_reg & plast_reg;
    assign sum  = acc_next;

endmodule

[rtl/integer_matrix_multiply_unit.sv]
// integer matrix multiply unit: a and b held in two rams, product read by dot product
// out-of-range request or zero inner_len gives its word in the cycle after start;
// a product request does one ram read per inner element, then waits for the mac sum
// stores give no word; busy stays high while a product is summed
// reset clears control and sets every size register to 16; ram contents are undefined
// depends on imm_pkg, imm_ram, imm_mac
module integer_matrix_multiply_unit #(
    parameter int unsigned MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  imm_pkg::in_word_t               cmd,
    output logic                            busy,
    input  logic                            cfg_write,
    input  logic [imm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]       cfg_data,
    output logic                            done,
    output imm_pkg::out_word_t              result
);

    localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [imm_pkg::DIM_W-1:0] rows_a_reg, inner_len_reg, cols_b_reg;
    logic [imm_pkg::DIM_W-1:0] rows_clamp, inner_clamp, cols_clamp;
    logic [imm_pkg::DIM_W-1:0] k_reg, k_next, n_reg, n_next;
    logic [ADDR_W-1:0]         a_addr_reg, a_addr_next, b_addr_reg, b_addr_next;
    logic [ADDR_W-1:0]         store_addr, a_ram_addr, b_ram_addr;
    logic                      rv_reg, rlast_reg, rd_last;
    logic                      done_reg, done_next;
    imm_pkg::out_word_t        result_reg, result_next;

    logic accept, store_ok, a_we, b_we, row_ok, col_ok, req_read;
    logic [imm_pkg::DATA_W-1:0] a_rdata, b_rdata, mac_sum;
    logic                       mac_done;
    imm_pkg::mac_ctl_t          mac_ctl;

    assign rows_clamp  = imm_pkg::clamp_dim(rows_a_reg, MAX_DIM);
    assign inner_clamp = imm_pkg::clamp_dim(inner_len_reg, MAX_DIM);
    assign cols_clamp  = imm_pkg::clamp_dim(cols_b_reg, MAX_DIM);

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start & ~busy;
    assign req_read = accept & (cmd.req_type == imm_pkg::REQ_READ);
    assign row_ok   = {1'b0, cmd.row_index} < rows_clamp;
    assign col_ok   = {1'b0, cmd.col_index} < cols_clamp;

    assign store_ok   = (32'(cmd.row_index) < MAX_DIM) && (32'(cmd.col_index) < MAX_DIM);
    assign store_addr = ADDR_W'(32'(cmd.row_index) * MAX_DIM + 32'(cmd.col_index));
    assign a_we       = accept & store_ok & (cmd.req_type == imm_pkg::REQ_STORE_A);
    assign b_we       = accept & store_ok & (cmd.req_type == imm_pkg::REQ_STORE_B);
    assign a_ram_addr = a_we ? store_addr : a_addr_reg;
    assign b_ram_addr = b_we ? store_addr : b_addr_reg;

    assign rd_last = (k_reg == n_reg - 1'b1);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= imm_pkg::DIM_RESET;
            inner_len_reg <= imm_pkg::DIM_RESET;
            cols_b_reg    <= imm_pkg::DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                imm_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                imm_pkg::CFG_INNER_LEN: inner_len_reg <= cfg_data;
                imm_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_read)
                begin
                    if (!(row_ok && col_ok))
                    begin
                        done_next                 = 1'b1;
                        result_next.product_value = '0;
                        result_next.range_error   = 1'b1;
                    end
                    else if (inner_clamp == '0)
                    begin
                        done_next                 = 1'b1;
                        result_next.product_value = '0;
                        result_next.range_error   = 1'b0;
                    end
                    else
                    begin
                        state_next  = ST_READ;
                        k_next      = '0;
                        n_next      = inner_clamp;
                        a_addr_next = ADDR_W'(32'(cmd.row_index) * MAX_DIM);
                        b_addr_next = ADDR_W'(cmd.col_index);
                    end
                end
            end
            ST_READ:
            begin
                k_next      = k_reg + 1'b1;
                a_addr_next = a_addr_reg + 1'b1;
                b_addr_next = b_addr_reg + ADDR_W'(MAX_DIM);
                if (rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next                = ST_IDLE;
                    done_next                 = 1'b1;
                    result_next.product_value = mac_sum;
                    result_next.range_error   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            rv_reg    <= 1'b0;
            rlast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            rv_reg    <= (state_reg == ST_READ);
            rlast_reg <= (state_reg == ST_READ) & rd_last;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        n_reg      <= n_next;
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        result_reg <= result_next;
    end

    assign mac_ctl.clear     = req_read;
    assign mac_ctl.mul_valid = rv_reg;
    assign mac_ctl.mul_last  = rlast_reg;

    imm_ram #(
        .WIDTH (imm_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .addr  (a_ram_addr),
        .wdata (cmd.element_value),
        .rdata (a_rdata)
    );

    imm_ram #(
        .WIDTH (imm_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .addr  (b_ram_addr),
        .wdata (cmd.element_value),
        .rdata (b_rdata)
    );

    imm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .done   (mac_done),
        .sum    (mac_sum)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/imm_checker.sv]
// port-level checks for the integer matrix multiply unit, bound to the top level
// depends on imm_pkg and integer_matrix_multiply_unit
module imm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input imm_pkg::in_word_t             cmd,
    input logic                          busy,
    input logic                          done,
    input imm_pkg::out_word_t            result
);

    // an error word carries zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.range_error |-> result.product_value == '0)
        else $error("range error word with nonzero value");

    // an accepted read either answers at once or starts summing
    a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.req_type == imm_pkg::REQ_READ |=> busy || done)
        else $error("read request neither answered nor started");

    // a store or other non-read request gives no word
    a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.req_type != imm_pkg::REQ_READ |=> !done)
        else $error("word after a non-read request");

    // the end of a sum always shows its word
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a word");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("word shown while busy");

endmodule

bind integer_matrix_multiply_unit imm_checker u_imm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
);
